/* rtl/core/rsp_pkg.sv */
// shared constants, types and handoff structs for the running sum with penalty block
// used by every module in rtl/core; depends on nothing
package rsp_pkg;

  localparam int HEAP_DEPTH = 1024;
  localparam int MAX_ITEMS  = 65536;

  localparam int ADDR_W  = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CNT_W   = $clog2(HEAP_DEPTH + 1);
  localparam int VAL_W   = 31;
  localparam int SUM_W   = VAL_W + ADDR_W;
  localparam int POS_W   = $clog2(MAX_ITEMS + 1);
  localparam int PEN_W   = 30;
  localparam int PROD_W  = POS_W + PEN_W;
  localparam int LIMIT_W = 11;
  localparam int IN_W    = 32;
  localparam int BEST_W  = 42;
  localparam int COUNT_W = 11;
  localparam int OUT_W   = 56;
  localparam int OUT_PAD_W = OUT_W - BEST_W - COUNT_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 30;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [VAL_W-1:0]   val_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [PEN_W-1:0]   pen_t;
  typedef logic [PROD_W-1:0]  prod_t;
  typedef logic [LIMIT_W-1:0] limit_t;
  typedef logic [BEST_W-1:0]  best_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_KEEP_LIMIT = 1'd0;
  localparam cfg_idx_t CFG_PENALTY    = 1'd1;

  localparam limit_t KEEP_LIMIT_RST = 11'd1024;

  typedef struct packed {
    logic   start;
    logic   sos;
    logic   nonneg;
    val_t   value;
    limit_t limit;
  } heap_cmd_t;

  typedef struct packed {
    logic done;
    cnt_t size;
    sum_t sum;
  } heap_stat_t;

endpackage

/* rtl/core/rsp_heap.sv */
// min-heap of kept values in a two-read one-write memory, plus kept count and running sum
// one heap level per cycle on both sift walks; depends on rsp_pkg
module rsp_heap (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rsp_pkg::heap_cmd_t cmd_i,
  output rsp_pkg::heap_stat_t stat_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_POP_CHK,
    ST_POP_RD,
    ST_FULL_CHK,
    ST_DOWN,
    ST_DONE
  } state_e;

  localparam int IDX_W = rsp_pkg::ADDR_W + 2;

  state_e         state_q, state_d;
  rsp_pkg::cnt_t  size_q, size_d;
  rsp_pkg::sum_t  sum_q, sum_d;
  rsp_pkg::addr_t pos_q, pos_d;
  rsp_pkg::val_t  v_q, v_d;
  rsp_pkg::cnt_t  lim_q, lim_d;

  rsp_pkg::val_t  mem [rsp_pkg::HEAP_DEPTH];
  rsp_pkg::val_t  rd_a_q, rd_b_q;
  rsp_pkg::addr_t ra, rb, wa;
  rsp_pkg::val_t  wd;
  logic           we;

  rsp_pkg::cnt_t  size0;
  rsp_pkg::sum_t  sum0;
  rsp_pkg::cnt_t  eff;
  rsp_pkg::addr_t up_par;
  rsp_pkg::addr_t up_next;
  logic [IDX_W-1:0] lidx, ridx, midx;
  logic [rsp_pkg::ADDR_W:0] kid_l, kid_r;
  rsp_pkg::addr_t kid_base;
  rsp_pkg::val_t  mv;
  logic           take_l, take_r;

  always_comb begin
    size0 = cmd_i.sos ? '0 : size_q;
    sum0  = cmd_i.sos ? '0 : sum_q;
    if (32'(cmd_i.limit) > 32'(rsp_pkg::HEAP_DEPTH)) begin
      eff = rsp_pkg::cnt_t'(rsp_pkg::HEAP_DEPTH);
    end else begin
      eff = rsp_pkg::cnt_t'(cmd_i.limit);
    end

    up_par  = rsp_pkg::addr_t'((pos_q - 1'b1) >> 1);
    up_next = rsp_pkg::addr_t'((up_par - 1'b1) >> 1);

    lidx = {1'b0, pos_q, 1'b1};
    ridx = lidx + 1'b1;
    take_l = (32'(lidx) < 32'(size_q)) && (rd_a_q < v_q);
    mv = take_l ? rd_a_q : v_q;
    take_r = (32'(ridx) < 32'(size_q)) && (rd_b_q < mv);
    if (take_r) begin
      midx = ridx;
      mv   = rd_b_q;
    end else begin
      midx = lidx;
    end

    state_d = state_q;
    size_d  = size_q;
    sum_d   = sum_q;
    pos_d   = pos_q;
    v_d     = v_q;
    lim_d   = lim_q;
    ra = '0;
    rb = '0;
    we = 1'b0;
    wa = pos_q;
    wd = v_q;
    kid_base = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.start) begin
          size_d = size0;
          sum_d  = sum0;
          lim_d  = eff;
          v_d    = cmd_i.value;
          if (!cmd_i.nonneg) begin
            state_d = ST_POP_CHK;
          end else if (32'(size0) < 32'(rsp_pkg::HEAP_DEPTH)) begin
            pos_d   = rsp_pkg::addr_t'(size0);
            size_d  = size0 + 1'b1;
            sum_d   = sum0 + rsp_pkg::sum_t'(cmd_i.value);
            ra      = rsp_pkg::addr_t'((rsp_pkg::addr_t'(size0) - 1'b1) >> 1);
            state_d = ST_UP;
          end else begin
            ra      = '0;
            state_d = ST_FULL_CHK;
          end
        end
      end
      ST_UP: begin
        we = 1'b1;
        if (pos_q == '0 || rd_a_q <= v_q) begin
          wd      = v_q;
          state_d = ST_POP_CHK;
        end else begin
          wd    = rd_a_q;
          pos_d = up_par;
          ra    = up_next;
        end
      end
      ST_POP_CHK: begin
        if (size_q > lim_q) begin
          ra      = '0;
          rb      = rsp_pkg::addr_t'(size_q - 1'b1);
          state_d = ST_POP_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_POP_RD: begin
        sum_d   = sum_q - rsp_pkg::sum_t'(rd_a_q);
        size_d  = size_q - 1'b1;
        v_d     = rd_b_q;
        pos_d   = '0;
        state_d = ST_DOWN;
      end
      ST_FULL_CHK: begin
        if (v_q > rd_a_q) begin
          sum_d   = sum_q - rsp_pkg::sum_t'(rd_a_q) + rsp_pkg::sum_t'(v_q);
          pos_d   = '0;
          state_d = ST_DOWN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DOWN: begin
        we = 1'b1;
        if (take_l || take_r) begin
          wd       = mv;
          pos_d    = midx[rsp_pkg::ADDR_W-1:0];
          kid_base = midx[rsp_pkg::ADDR_W-1:0];
        end else begin
          wd      = v_q;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // child reads for the next sift-down level
    kid_l = {kid_base, 1'b1};
    kid_r = kid_l + 1'b1;
    if (state_q == ST_POP_RD || state_q == ST_FULL_CHK || state_q == ST_DOWN) begin
      ra = kid_l[rsp_pkg::ADDR_W-1:0];
      rb = kid_r[rsp_pkg::ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_q <= mem[ra];
    rd_b_q <= mem[rb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      size_q  <= '0;
      sum_q   <= '0;
      pos_q   <= '0;
      v_q     <= '0;
      lim_q   <= '0;
    end else begin
      state_q <= state_d;
      size_q  <= size_d;
      sum_q   <= sum_d;
      pos_q   <= pos_d;
      v_q     <= v_d;
      lim_q   <= lim_d;
    end
  end

  assign stat_o.done = (state_q == ST_DONE);
  assign stat_o.size = size_q;
  assign stat_o.sum  = sum_q;

endmodule

/* rtl/core/rsp_score.sv */
// item position, registered penalty product and best score so far
// depends on rsp_pkg
module rsp_score (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          sos_i,
  input  rsp_pkg::pen_t penalty_i,
  input  logic          fin_i,
  input  rsp_pkg::sum_t sum_i,
  output rsp_pkg::sum_t best_o
);

  rsp_pkg::pos_t  pos_q, pos_d;
  rsp_pkg::prod_t prod_q;
  rsp_pkg::sum_t  best_q, best_d;
  rsp_pkg::pos_t  pos0;
  logic [63:0]    diff;

  always_comb begin
    pos0   = sos_i ? '0 : pos_q;
    pos_d  = pos_q;
    best_d = best_q;
    diff   = 64'(sum_i) - 64'(prod_q);
    if (start_i) begin
      pos_d = (32'(pos0) < 32'(rsp_pkg::MAX_ITEMS)) ? pos0 + 1'b1 : pos0;
      if (sos_i) begin
        best_d = '0;
      end
    end else if (fin_i) begin
      if (64'(sum_i) > 64'(prod_q) && rsp_pkg::sum_t'(diff) > best_q) begin
        best_d = rsp_pkg::sum_t'(diff);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      best_q <= '0;
    end else begin
      pos_q  <= pos_d;
      best_q <= best_d;
    end
  end

  // multiplier output register
  always_ff @(posedge clk_i) begin
    prod_q <= rsp_pkg::prod_t'(pos_q) * rsp_pkg::prod_t'(penalty_i);
  end

  assign best_o = best_q;

endmodule

/* rtl/core/top_m_running_sum_with_penalty_unit.sv */
// The heap memory is walked one level per cycle, first up for an insert, then down for a
// removal or a replacement of the minimum. A finished result sits in the output register
// while the next item is taken and worked on.
// Top level: stream ports, configuration registers, result register; uses rsp_pkg,
// rsp_heap and rsp_score
module top_m_running_sum_with_penalty_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [rsp_pkg::IN_W-1:0]      s_axis_tdata_i,  // value
  input  logic [0:0]                    s_axis_tuser_i,  // start_of_case
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [rsp_pkg::OUT_W-1:0]     m_axis_tdata_o,  // best_value, kept_count, zero pad
  input  logic                          cfg_we_i,
  input  rsp_pkg::cfg_idx_t             cfg_idx_i,
  input  logic [rsp_pkg::CFG_W-1:0]     cfg_data_i
);

  rsp_pkg::limit_t     keep_limit_q;
  rsp_pkg::pen_t       penalty_q;
  logic                busy_q, pend_q, m_valid_q;
  logic [rsp_pkg::OUT_W-1:0] m_data_q;
  logic                s_fire, load;
  rsp_pkg::heap_cmd_t  cmd;
  rsp_pkg::heap_stat_t stat;
  rsp_pkg::sum_t       best;

  assign s_axis_tready_o = !busy_q;
  assign s_fire = s_axis_tvalid_i && !busy_q;
  assign load   = pend_q && (!m_valid_q || m_axis_tready_i);

  assign cmd.start  = s_fire;
  assign cmd.sos    = s_axis_tuser_i[0];
  assign cmd.nonneg = !s_axis_tdata_i[rsp_pkg::IN_W-1];
  assign cmd.value  = s_axis_tdata_i[rsp_pkg::VAL_W-1:0];
  assign cmd.limit  = keep_limit_q;

  rsp_heap u_heap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  rsp_score u_score (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (s_fire),
    .sos_i     (s_axis_tuser_i[0]),
    .penalty_i (penalty_q),
    .fin_i     (stat.done),
    .sum_i     (stat.sum),
    .best_o    (best)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_limit_q <= rsp_pkg::KEEP_LIMIT_RST;
      penalty_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rsp_pkg::CFG_KEEP_LIMIT: keep_limit_q <= cfg_data_i[rsp_pkg::LIMIT_W-1:0];
        rsp_pkg::CFG_PENALTY:    penalty_q    <= cfg_data_i[rsp_pkg::PEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (s_fire) begin
        busy_q <= 1'b1;
      end else if (load) begin
        busy_q <= 1'b0;
      end
      if (stat.done) begin
        pend_q <= 1'b1;
      end else if (load) begin
        pend_q <= 1'b0;
      end
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      m_data_q <= {{rsp_pkg::OUT_PAD_W{1'b0}}, rsp_pkg::count_t'(stat.size),
                   rsp_pkg::best_t'(best)};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for top_m_running_sum_with_penalty_unit: a directed table, then random
// phases, each item scored by a min-heap predictor in the bench; depends on rsp_pkg and the rtl
module testbench;
  import rsp_pkg::*;

  localparam int          CLK_PERIOD  = 8;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

  typedef struct packed {
    best_t  best;
    count_t count;
  } score_t;

  typedef struct {
    row_kind_e       kind;
    cfg_idx_t        idx;
    logic [CFG_W-1:0] data;
    logic [IN_W-1:0] value;
    logic            sos;
    bit              typed;
    score_t          want;
  } plan_row_t;

  typedef struct {
    limit_t      limit;
    pen_t        penalty;
    int unsigned items;
    int unsigned sos_pct;
    int unsigned neg_pct;
    int unsigned gap_pct;
    int unsigned stall_pct;
    bit          opens_case;
  } phase_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [IN_W-1:0]      s_axis_tdata_i;   // value
  logic [0:0]           s_axis_tuser_i;   // start_of_case
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [OUT_W-1:0]     m_axis_tdata_o;   // best_value, kept_count, zero pad
  logic                 cfg_we_i;
  cfg_idx_t             cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  top_m_running_sum_with_penalty_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // predictor state
  val_t   kept_heap [HEAP_DEPTH];
  cnt_t   kept_n;
  sum_t   kept_sum;
  pos_t   case_pos;
  prod_t  case_penalty;
  best_t  case_best;
  limit_t limit_cfg;
  pen_t   penalty_cfg;

  score_t      scores_due [$];
  int unsigned errors;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned writes_done;
  int unsigned peak_kept;
  int unsigned stall_pct;

  function automatic void clear_case_state();
    kept_n       = '0;
    kept_sum     = '0;
    case_pos     = '0;
    case_penalty = '0;
    case_best    = '0;
  endfunction

  function automatic void heap_rise(int unsigned p);
    int unsigned up;
    val_t        t;
    bit          done;
    done = 1'b0;
    while (p > 0 && !done) begin
      up = (p - 1) / 2;
      if (kept_heap[up] <= kept_heap[p]) begin
        done = 1'b1;
      end else begin
        t = kept_heap[up];
        kept_heap[up] = kept_heap[p];
        kept_heap[p] = t;
        p = up;
      end
    end
  endfunction

  function automatic void heap_sink(int unsigned p);
    int unsigned l;
    int unsigned r;
    int unsigned m;
    val_t        t;
    bit          done;
    done = 1'b0;
    while (!done) begin
      l = 2 * p + 1;
      r = l + 1;
      m = p;
      if (l < kept_n && kept_heap[l] < kept_heap[m]) m = l;
      if (r < kept_n && kept_heap[r] < kept_heap[m]) m = r;
      if (m == p) begin
        done = 1'b1;
      end else begin
        t = kept_heap[m];
        kept_heap[m] = kept_heap[p];
        kept_heap[p] = t;
        p = m;
      end
    end
  endfunction

  function automatic void drop_smallest();
    if (kept_n != 0) begin
      kept_sum = kept_sum - kept_heap[0];
      kept_n = kept_n - 1'b1;
      kept_heap[0] = kept_heap[kept_n];
      heap_sink(0);
    end
  endfunction

  function automatic score_t score_item(logic [IN_W-1:0] value, logic sos);
    int unsigned eff;
    val_t        v;
    prod_t       gain;
    score_t      s;
    eff = (limit_cfg < HEAP_DEPTH) ? limit_cfg : HEAP_DEPTH;
    v = value[VAL_W-1:0];
    if (sos) clear_case_state();
    if (!value[IN_W-1]) begin
      if (kept_n < HEAP_DEPTH) begin
        kept_heap[kept_n] = v;
        kept_sum = kept_sum + v;
        kept_n = kept_n + 1'b1;
        heap_rise(kept_n - 1);
        if (kept_n > eff) drop_smallest();
      end else if (v > kept_heap[0]) begin
        kept_sum = kept_sum - kept_heap[0] + v;
        kept_heap[0] = v;
        heap_sink(0);
      end
    end else if (kept_n > eff) begin
      drop_smallest();
    end
    if (case_pos < MAX_ITEMS) case_pos = case_pos + 1'b1;
    case_penalty = prod_t'(case_pos) * prod_t'(penalty_cfg);
    if (prod_t'(kept_sum) > case_penalty) begin
      gain = prod_t'(kept_sum) - case_penalty;
      if (gain > prod_t'(case_best)) case_best = best_t'(gain);
    end
    if (kept_n > peak_kept) peak_kept = kept_n;
    s.best  = case_best;
    s.count = count_t'(kept_n);
    return s;
  endfunction

  function automatic int unsigned gap_len();
    return ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [IN_W-1:0] pick_value(int unsigned neg_pct);
    logic [IN_W-1:0] v;
    v = $urandom;
    if ($urandom_range(99) < neg_pct) begin
      v[IN_W-1] = 1'b1;
    end else begin
      v[IN_W-1] = 1'b0;
      case ($urandom_range(3))
        0: v = $urandom_range(255);
        1: v = 32'h7FFF_FFFF - $urandom_range(255);
        2: v = v & 32'h000F_FFFF;
        default: ;
      endcase
    end
    return v;
  endfunction

  function automatic plan_row_t item_row(logic [IN_W-1:0] value, logic sos);
    plan_row_t r;
    r = '{kind: ROW_ITEM, idx: CFG_KEEP_LIMIT, data: '0, value: value, sos: sos,
          typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic plan_row_t typed_row(logic [IN_W-1:0] value, logic sos,
                                          best_t best, count_t count);
    plan_row_t r;
    r = item_row(value, sos);
    r.typed = 1'b1;
    r.want.best = best;
    r.want.count = count;
    return r;
  endfunction

  function automatic plan_row_t write_row(cfg_idx_t idx, logic [CFG_W-1:0] data);
    plan_row_t r;
    r = item_row('0, 1'b0);
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic phase_t make_phase(limit_t limit, pen_t penalty, int unsigned items,
                                        int unsigned sos_pct, int unsigned neg_pct,
                                        int unsigned gap_pct, int unsigned stall,
                                        bit opens_case);
    phase_t p;
    p = '{limit: limit, penalty: penalty, items: items, sos_pct: sos_pct, neg_pct: neg_pct,
          gap_pct: gap_pct, stall_pct: stall, opens_case: opens_case};
    return p;
  endfunction

  task automatic send_item(logic [IN_W-1:0] value, logic sos, bit typed, score_t typed_score);
    score_t s;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tuser_i  <= sos;
    do @(posedge clk_i); while (!s_axis_tready_o);
    s = score_item(value, sos);
    if (typed) s = typed_score;
    scores_due = {scores_due, s};
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic maybe_gap(int unsigned gap_pct);
    if ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap_len()) @(negedge clk_i);
    end
  endtask

  // block is idle once every result is back
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (scores_due.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    if (idx == CFG_KEEP_LIMIT) limit_cfg = data[LIMIT_W-1:0];
    else penalty_cfg = data[PEN_W-1:0];
    writes_done++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    score_t got;
    score_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.best  = m_axis_tdata_o[BEST_W-1:0];
      got.count = m_axis_tdata_o[BEST_W+COUNT_W-1:BEST_W];
      results_seen++;
      if (scores_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected item out, best %0d count %0d", $time, got.best, got.count);
      end else begin
        want = scores_due.pop_front();
        if (got.best !== want.best) begin
          errors++;
          $display("%0t: best_value expected %0d actual %0d", $time, want.best, got.best);
        end
        if (got.count !== want.count) begin
          errors++;
          $display("%0t: kept_count expected %0d actual %0d", $time, want.count, got.count);
        end
      end
    end
  end

  // output side backpressure
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
        stall_left = gap_len() - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: no progress, %0d results still outstanding", $time, scores_due.size());
    $display("top_m_running_sum_with_penalty_unit regression: fail");
    $finish;
  end

  initial begin
    plan_row_t   plan [$];
    phase_t      phases [$];
    int unsigned gap_pct;
    logic        sos;

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_KEEP_LIMIT;
    cfg_data_i      = '0;
    errors          = 0;
    items_sent      = 0;
    results_seen    = 0;
    writes_done     = 0;
    peak_kept       = 0;
    stall_pct       = 25;
    gap_pct         = 25;
    foreach (kept_heap[i]) kept_heap[i] = '0;
    clear_case_state();
    limit_cfg   = KEEP_LIMIT_RST;
    penalty_cfg = '0;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: limit 1024, no penalty
    plan = {plan, typed_row(32'h0000_0000, 1'b1, 42'd0, 11'd1)};
    plan = {plan, typed_row(32'h7FFF_FFFF, 1'b0, 42'h7FFF_FFFF, 11'd2)};
    plan = {plan, typed_row(32'h8000_0000, 1'b0, 42'h7FFF_FFFF, 11'd2)};
    plan = {plan, typed_row(32'hFFFF_FFFF, 1'b0, 42'h7FFF_FFFF, 11'd2)};
    plan = {plan, typed_row(32'h7FFF_FFFF, 1'b1, 42'h7FFF_FFFF, 11'd1)};
    // zero limit: pushed and popped at once
    plan = {plan, write_row(CFG_KEEP_LIMIT, 30'd0)};
    plan = {plan, typed_row(32'd100, 1'b1, 42'd0, 11'd0)};
    plan = {plan, typed_row(32'h7FFF_FFFF, 1'b0, 42'd0, 11'd0)};
    plan = {plan, write_row(CFG_KEEP_LIMIT, 30'd2)};
    plan = {plan, typed_row(32'd10, 1'b1, 42'd10, 11'd1)};
    plan = {plan, typed_row(32'd20, 1'b0, 42'd30, 11'd2)};
    plan = {plan, typed_row(32'd5, 1'b0, 42'd30, 11'd2)};
    plan = {plan, typed_row(32'd40, 1'b0, 42'd60, 11'd2)};
    // limit lowered mid-case: one removal per item
    plan = {plan, write_row(CFG_KEEP_LIMIT, 30'd1)};
    plan = {plan, typed_row(32'hFFFF_FFFD, 1'b0, 42'd60, 11'd1)};
    plan = {plan, write_row(CFG_PENALTY, 30'd10)};
    plan = {plan, typed_row(32'd50, 1'b1, 42'd40, 11'd1)};
    plan = {plan, typed_row(32'd50, 1'b0, 42'd40, 11'd1)};
    plan = {plan, write_row(CFG_PENALTY, 30'h3FFF_FFFF)};
    plan = {plan, typed_row(32'h7FFF_FFFF, 1'b1, 42'h4000_0000, 11'd1)};
    plan = {plan, typed_row(32'h7FFF_FFFF, 1'b0, 42'h4000_0000, 11'd1)};
    // difference below zero leaves best alone
    plan = {plan, typed_row(32'h0000_0000, 1'b0, 42'h4000_0000, 11'd1)};
    // limit above heap capacity
    plan = {plan, write_row(CFG_KEEP_LIMIT, 30'd2047)};
    plan = {plan, write_row(CFG_PENALTY, 30'd0)};
    plan = {plan, typed_row(32'd1, 1'b1, 42'd1, 11'd1)};
    plan = {plan, typed_row(32'h8000_0001, 1'b1, 42'd0, 11'd0)};
    plan = {plan, item_row(32'h1234_5678, 1'b0)};
    plan = {plan, item_row(32'h0000_0001, 1'b0)};

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        maybe_gap(gap_pct);
        send_item(plan[i].value, plan[i].sos, plan[i].typed, plan[i].want);
      end
    end

    phases = {phases, make_phase(11'd3, pen_t'($urandom_range(4096)), 120, 8, 20, 30, 30,
                                 1'b1)};
    phases = {phases, make_phase(11'd0, pen_t'($urandom_range(1000)), 30, 10, 25, 20, 20,
                                 1'b1)};
    // large limit, long case with few negatives
    phases = {phases, make_phase(11'd2047, '0, 200, 0, 2, 10, 10, 1'b1)};
    phases = {phases, make_phase(11'd5, pen_t'(3), 40, 0, 80, 25, 25, 1'b0)};
    phases = {phases, make_phase(11'd1024, pen_t'($urandom_range(1 << 24)), 150, 3, 15, 0, 0,
                                 1'b1)};
    phases = {phases, make_phase(11'd1, pen_t'(30'h3FFF_FFFF), 60, 10, 20, 40, 40, 1'b1)};
    phases = {phases, make_phase(limit_t'($urandom_range(1, 64)),
                                 pen_t'($urandom >> $urandom_range(2, 31)), 200, 5, 15, 30, 30,
                                 1'b1)};
    phases = {phases, make_phase(11'd4, pen_t'(1), 24, 0, 0, 10, 10, 1'b0)};
    phases = {phases, make_phase(limit_t'($urandom_range(2047)),
                                 pen_t'($urandom_range(1 << 16)), 100, 5, 30, 50, 50, 1'b1)};

    foreach (phases[k]) begin
      settle();
      write_reg(CFG_KEEP_LIMIT, CFG_W'(($urandom & ~32'h7FF) | 32'(phases[k].limit)));
      write_reg(CFG_PENALTY, CFG_W'(phases[k].penalty));
      stall_pct = phases[k].stall_pct;
      for (int unsigned n = 0; n < phases[k].items; n++) begin
        sos = (n == 0) ? phases[k].opens_case : ($urandom_range(99) < phases[k].sos_pct);
        maybe_gap(phases[k].gap_pct);
        send_item(pick_value(phases[k].neg_pct), sos, 1'b0, '0);
      end
    end

    settle();
    repeat (30) @(negedge clk_i);
    $display("sent %0d items in %0d phases with %0d register writes, largest kept set %0d",
             items_sent, phases.size(), writes_done, peak_kept);
    $display("checked %0d results, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("top_m_running_sum_with_penalty_unit regression: pass");
    end else begin
      $display("top_m_running_sum_with_penalty_unit regression: fail");
    end
    $finish;
  end

endmodule
